>>> sv/dmfp_pkg.sv
// Shared types, codes and constants of the DNS message field parser.
package dmfp_pkg;

  localparam int MAX_NAME_BYTES_DEF = 255;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_NAME_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ANSWER_ENABLE = 2'd1;

  localparam int HEADER_BYTES = 12;
  localparam int ANS_FIXED = 12;
  localparam int ADDR_BYTES = 16;
  localparam int ANS_TOTAL = ANS_FIXED + ADDR_BYTES;
  localparam int QR_SHIFT = 7;
  localparam int FLAGS_HI_BYTE = 2;
  localparam int ANCOUNT_LO_BYTE = 7;
  localparam int QTYPE_LO_BYTE = 1;
  localparam int QCLASS_LO_BYTE = 3;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_LABEL,
    PH_QFIXED,
    PH_ANSWER,
    PH_DONE
  } phase_t;

  localparam logic [4:0] KIND_ID        = 5'd0;
  localparam logic [4:0] KIND_NAME_CHAR = 5'd6;
  localparam logic [4:0] KIND_NAME_END  = 5'd7;
  localparam logic [4:0] KIND_QTYPE     = 5'd8;
  localparam logic [4:0] KIND_QCLASS    = 5'd9;
  localparam logic [4:0] KIND_AN_NAME   = 5'd10;
  localparam logic [4:0] KIND_AN_TYPE   = 5'd11;
  localparam logic [4:0] KIND_AN_CLASS  = 5'd12;
  localparam logic [4:0] KIND_AN_TTL    = 5'd13;
  localparam logic [4:0] KIND_AN_RDLEN  = 5'd14;
  localparam logic [4:0] KIND_ADDR      = 5'd15;
  localparam logic [4:0] KIND_ERROR     = 5'd16;
  localparam logic [4:0] KIND_DONE      = 5'd17;

  localparam logic [31:0] ERR_LONG_NAME = 32'd0;
  localparam logic [31:0] ERR_POINTER   = 32'd1;
  localparam logic [31:0] ERR_EARLY_END = 32'd2;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] value;
    logic        is_response;
    logic [2:0]  group_index;
    logic        last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> sv/dmfp_front.sv
// Front end: configuration registers and the byte-by-byte message parser.
module dmfp_front #(
  parameter int MAX_NAME_BYTES = dmfp_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dmfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dmfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept,
  input  logic [7:0]                       msg_byte,
  input  logic                             end_of_message,
  output logic                             push,
  output dmfp_pkg::result_t                result
);
  import dmfp_pkg::*;

  localparam logic [7:0] NAME_CAP = 8'(MAX_NAME_BYTES);

  phase_t      phase, phase_next;
  logic [4:0]  byte_in_phase, byte_in_phase_next;
  logic [5:0]  label_remaining, label_remaining_next;
  logic [7:0]  name_count, name_count_next;
  logic        first_label, first_label_next;
  logic [31:0] field_accumulator, field_accumulator_next;
  logic [15:0] answer_count_seen, answer_count_seen_next;
  logic        response_bit, response_bit_next;
  logic        error_hold, error_hold_next;
  logic [7:0]  max_name_length;
  logic        answer_enable;

  logic        have;
  logic [4:0]  r_kind;
  logic [31:0] r_value;
  logic [2:0]  r_group;
  logic        r_resp;
  logic [7:0]  name_limit;
  logic [15:0] acc16;
  logic [31:0] acc32;
  logic [4:0]  bip_inc;
  logic [4:0]  addr_off;
  logic [5:0]  label_dec;

  assign name_limit = (max_name_length < NAME_CAP) ? max_name_length : NAME_CAP;
  assign acc16      = {field_accumulator[7:0], msg_byte};
  assign acc32      = {field_accumulator[23:0], msg_byte};
  assign bip_inc    = byte_in_phase + 5'd1;
  assign addr_off   = byte_in_phase - 5'(ANS_FIXED);
  assign label_dec  = label_remaining - 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_length <= 8'd255;
      answer_enable   <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_NAME_LENGTH) begin
        max_name_length <= cfg_data[7:0];
      end else if (cfg_index == REG_ANSWER_ENABLE) begin
        answer_enable <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      byte_in_phase     <= '0;
      label_remaining   <= '0;
      name_count        <= '0;
      first_label       <= 1'b1;
      field_accumulator <= '0;
      answer_count_seen <= '0;
      response_bit      <= 1'b0;
      error_hold        <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      byte_in_phase     <= byte_in_phase_next;
      label_remaining   <= label_remaining_next;
      name_count        <= name_count_next;
      first_label       <= first_label_next;
      field_accumulator <= field_accumulator_next;
      answer_count_seen <= answer_count_seen_next;
      response_bit      <= response_bit_next;
      error_hold        <= error_hold_next;
    end
  end

  always_comb begin
    phase_next             = phase;
    byte_in_phase_next     = byte_in_phase;
    label_remaining_next   = label_remaining;
    name_count_next        = name_count;
    first_label_next       = first_label;
    field_accumulator_next = field_accumulator;
    answer_count_seen_next = answer_count_seen;
    response_bit_next      = response_bit;
    error_hold_next        = error_hold;
    have                   = 1'b0;
    r_kind                 = KIND_ID;
    r_value                = '0;
    r_group                = '0;

    if (error_hold || phase == PH_DONE) begin
      if (end_of_message) begin
        have   = 1'b1;
        r_kind = KIND_DONE;
      end
    end else begin
      unique case (phase)
        PH_HEADER: begin
          field_accumulator_next = {16'd0, acc16};
          if (byte_in_phase == 5'(FLAGS_HI_BYTE)) begin
            response_bit_next = msg_byte[QR_SHIFT];
          end
          byte_in_phase_next = bip_inc;
          if (bip_inc >= 5'(HEADER_BYTES)) begin
            phase_next         = PH_LENGTH;
            byte_in_phase_next = '0;
            first_label_next   = 1'b1;
            name_count_next    = '0;
          end
          if (byte_in_phase[0]) begin
            have    = 1'b1;
            r_kind  = {1'b0, byte_in_phase[4:1]};
            r_value = {16'd0, acc16};
            if (byte_in_phase == 5'(ANCOUNT_LO_BYTE)) begin
              answer_count_seen_next = acc16;
            end
            field_accumulator_next = '0;
          end
        end
        PH_LENGTH: begin
          if (msg_byte == 8'd0) begin
            have                   = 1'b1;
            r_kind                 = KIND_NAME_END;
            r_value                = {24'd0, name_count};
            phase_next             = PH_QFIXED;
            byte_in_phase_next     = '0;
            field_accumulator_next = '0;
          end else if (msg_byte[7:6] != 2'b00) begin
            error_hold_next = 1'b1;
            have            = 1'b1;
            r_kind          = KIND_ERROR;
            r_value         = ERR_POINTER;
          end else begin
            label_remaining_next = msg_byte[5:0];
            phase_next           = PH_LABEL;
            if (!first_label) begin
              have = 1'b1;
              if (name_count >= name_limit) begin
                error_hold_next = 1'b1;
                r_kind          = KIND_ERROR;
                r_value         = ERR_LONG_NAME;
              end else begin
                name_count_next = name_count + 8'd1;
                r_kind          = KIND_NAME_CHAR;
                r_value         = {24'd0, DOT_CHAR};
              end
            end else begin
              first_label_next = 1'b0;
            end
          end
        end
        PH_LABEL: begin
          have = 1'b1;
          if (name_count >= name_limit) begin
            error_hold_next = 1'b1;
            r_kind          = KIND_ERROR;
            r_value         = ERR_LONG_NAME;
          end else begin
            name_count_next      = name_count + 8'd1;
            label_remaining_next = label_dec;
            if (label_dec == 6'd0) begin
              phase_next = PH_LENGTH;
            end
            r_kind  = KIND_NAME_CHAR;
            r_value = {24'd0, msg_byte};
          end
        end
        PH_QFIXED: begin
          field_accumulator_next = {16'd0, acc16};
          byte_in_phase_next     = bip_inc;
          if (byte_in_phase[0]) begin
            have    = 1'b1;
            r_kind  = (byte_in_phase == 5'(QTYPE_LO_BYTE)) ? KIND_QTYPE : KIND_QCLASS;
            r_value = {16'd0, acc16};
            field_accumulator_next = '0;
            if (byte_in_phase >= 5'(QCLASS_LO_BYTE)) begin
              phase_next = (answer_enable && answer_count_seen != 16'd0) ? PH_ANSWER
                                                                         : PH_DONE;
              byte_in_phase_next = '0;
            end
          end
        end
        PH_ANSWER: begin
          field_accumulator_next = acc32;
          byte_in_phase_next     = bip_inc;
          if (bip_inc >= 5'(ANS_TOTAL)) begin
            phase_next = PH_DONE;
          end
          if (byte_in_phase >= 5'(ANS_FIXED)) begin
            if (byte_in_phase[0]) begin
              have    = 1'b1;
              r_kind  = KIND_ADDR;
              r_group = addr_off[3:1];
            end
          end else begin
            unique case (byte_in_phase)
              5'd1: begin
                have   = 1'b1;
                r_kind = KIND_AN_NAME;
              end
              5'd3: begin
                have   = 1'b1;
                r_kind = KIND_AN_TYPE;
              end
              5'd5: begin
                have   = 1'b1;
                r_kind = KIND_AN_CLASS;
              end
              5'd9: begin
                have   = 1'b1;
                r_kind = KIND_AN_TTL;
              end
              5'd11: begin
                have   = 1'b1;
                r_kind = KIND_AN_RDLEN;
              end
              default: begin
                have = 1'b0;
              end
            endcase
          end
          if (have) begin
            r_value                = acc32;
            field_accumulator_next = '0;
          end
        end
        PH_DONE: begin
          have = 1'b0;
        end
      endcase

      if (end_of_message) begin
        priority if (error_hold_next) begin
          have = 1'b1;
        end else if (phase_next != PH_DONE) begin
          have    = 1'b1;
          r_kind  = KIND_ERROR;
          r_value = ERR_EARLY_END;
          r_group = '0;
        end else if (!have) begin
          have    = 1'b1;
          r_kind  = KIND_DONE;
          r_value = '0;
          r_group = '0;
        end else begin
          have = 1'b1;
        end
      end
    end

    r_resp = response_bit_next;

    // return to the header after the final byte
    if (end_of_message) begin
      phase_next             = PH_HEADER;
      byte_in_phase_next     = '0;
      label_remaining_next   = '0;
      name_count_next        = '0;
      first_label_next       = 1'b1;
      field_accumulator_next = '0;
      answer_count_seen_next = '0;
      response_bit_next      = 1'b0;
      error_hold_next        = 1'b0;
    end
  end

  assign push               = accept && have;
  assign result.kind        = r_kind;
  assign result.value       = r_value;
  assign result.is_response = r_resp;
  assign result.group_index = r_group;
  assign result.last        = end_of_message;

endmodule

>>> sv/dmfp_queue.sv
// Result queue between the parser and the output stage.
module dmfp_queue #(
  parameter int QUEUE_DEPTH = dmfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  dmfp_pkg::result_t       push_data,
  input  logic                    pop,
  output dmfp_pkg::result_t       head,
  output dmfp_pkg::queue_status_t status
);
  import dmfp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  result_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_comb begin
    count_next = count;
    unique case ({push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == FULL_COUNT);
  assign status.empty = (count == '0);

endmodule

>>> sv/dmfp_back.sv
// Back end: output register that drains the result queue.
module dmfp_back (
  input  logic                    clk,
  input  logic                    rst,
  input  dmfp_pkg::result_t       head,
  input  dmfp_pkg::queue_status_t status,
  output logic                    pop,
  input  logic                    out_stall,
  output logic                    out_valid,
  output dmfp_pkg::result_t       out_data
);
  import dmfp_pkg::*;

  logic out_valid_next;

  assign pop = !status.empty && (!out_valid || !out_stall);

  always_comb begin
    priority if (pop) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head;
    end
  end

endmodule

>>> sv/dns_message_field_parser.sv
// Top level of the DNS message field parser: parser, result queue, output stage.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_stall       msg_byte, end_of_message
//   out      output     out_valid / out_stall     kind, value, is_response,
//                                                 group_index, last
//   cfg      input      cfg_we                    cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; the parser state updates in the cycle of the transfer.
// A result is written into a queue slot when its byte is transferred and then moves on into the output register.
// in_stall rises only when the result queue is full; out_stall backs up the queue.
// Synchronous reset returns the parser to the header and empties the queue.
module dns_message_field_parser #(
  parameter int MAX_NAME_BYTES = dmfp_pkg::MAX_NAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = dmfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dmfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dmfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       msg_byte,
  input  logic                             end_of_message,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [4:0]                       kind,
  output logic [31:0]                      value,
  output logic                             is_response,
  output logic [2:0]                       group_index,
  output logic                             last
);
  import dmfp_pkg::*;

  logic          accept;
  logic          push;
  logic          pop;
  result_t       front_result;
  result_t       head;
  result_t       out_data;
  queue_status_t q_status;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  dmfp_front #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .msg_byte      (msg_byte),
    .end_of_message(end_of_message),
    .push          (push),
    .result        (front_result)
  );

  dmfp_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(front_result),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  dmfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .status   (q_status),
    .pop      (pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  assign kind        = out_data.kind;
  assign value       = out_data.value;
  assign is_response = out_data.is_response;
  assign group_index = out_data.group_index;
  assign last        = out_data.last;

`ifndef SYNTHESIS
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> kind == KIND_DONE || kind == KIND_ERROR ||
                          kind == KIND_QCLASS || kind == KIND_ADDR)
    else $error("last on a result that cannot end a message");

  a_group_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_ADDR |-> group_index == 3'd0)
    else $error("group index set outside address groups");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && q_status.empty |=> !out_valid)
    else $error("output valid without a queued result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !q_status.full)
    else $error("output or queue not cleared by reset");
`endif

endmodule
